@@ hdl/aosfb_pkg.sv @@
// ----------------------------------------------------------------------------
// aosfb_pkg
// Shared types, constants and the crc-16-ccitt byte update of the transfer
// frame builder.
// ----------------------------------------------------------------------------
package aosfb_pkg;

	// configuration port geometry
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_CHANNEL_HDR = 3'd0,
		CFG_DATA_HDR    = 3'd1,
		CFG_PACKET_ID   = 3'd2,
		CFG_CTRL_ONE    = 3'd3,
		CFG_CTRL_TWO    = 3'd4
	} cfg_idx_t;

	// configuration register set
	typedef struct packed {
		logic [15:0] channel_header_word;
		logic [15:0] data_header_word;
		logic [7:0]  packet_id_byte;
		logic [15:0] control_word_one;
		logic [15:0] control_word_two;
	} cfg_t;

	// register reset values
	localparam logic [15:0] ChannelHdrRst = 16'hC074;
	localparam logic [15:0] DataHdrRst    = 16'h00EA;
	localparam logic [7:0]  PacketIdRst   = 8'hAF;
	localparam logic [15:0] CtrlOneRst    = 16'h0080;
	localparam logic [15:0] CtrlTwoRst    = 16'h0000;

	// attached sync marker
	localparam logic [7:0] Sync0 = 8'h1A;
	localparam logic [7:0] Sync1 = 8'hCF;
	localparam logic [7:0] Sync2 = 8'hFC;
	localparam logic [7:0] Sync3 = 8'h1D;

	// frame layout around the payload
	localparam int HeadBytes = 80;
	localparam int CrcFirst  = 4;
	localparam int TailBytes = 6;
	localparam int LenExtra  = 5;

	// byte positions inside the frame head
	localparam logic [6:0] PosSync0   = 7'd0;
	localparam logic [6:0] PosSync1   = 7'd1;
	localparam logic [6:0] PosSync2   = 7'd2;
	localparam logic [6:0] PosSync3   = 7'd3;
	localparam logic [6:0] PosChanHi  = 7'd4;
	localparam logic [6:0] PosChanLo  = 7'd5;
	localparam logic [6:0] PosFcHi    = 7'd7;
	localparam logic [6:0] PosFcLo    = 7'd8;
	localparam logic [6:0] PosDhdrHi  = 7'd75;
	localparam logic [6:0] PosDhdrLo  = 7'd76;
	localparam logic [6:0] PosLenHi   = 7'd77;
	localparam logic [6:0] PosLenLo   = 7'd78;
	localparam logic [6:0] PosPid     = 7'd79;

	// byte offsets inside the frame tail
	localparam logic [2:0] TailCw1Hi = 3'd0;
	localparam logic [2:0] TailCw1Lo = 3'd1;
	localparam logic [2:0] TailCw2Hi = 3'd2;
	localparam logic [2:0] TailCw2Lo = 3'd3;
	localparam logic [2:0] TailCrcHi = 3'd4;
	localparam logic [2:0] TailCrcLo = 3'd5;

	// crc-16-ccitt, msb first
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'h1021;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
		end
		return c;
	endfunction

endpackage

@@ hdl/aosfb_payload_ram.sv @@
// ----------------------------------------------------------------------------
// aosfb_payload_ram
// Payload byte buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module aosfb_payload_ram #(
	parameter int DEPTH = 810,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/aosfb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// aosfb_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module aosfb_cfg_regs import aosfb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_header_word <= ChannelHdrRst;
			cfg_q.data_header_word    <= DataHdrRst;
			cfg_q.packet_id_byte      <= PacketIdRst;
			cfg_q.control_word_one    <= CtrlOneRst;
			cfg_q.control_word_two    <= CtrlTwoRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CHANNEL_HDR: cfg_q.channel_header_word <= cfg_data;
				CFG_DATA_HDR:    cfg_q.data_header_word    <= cfg_data;
				CFG_PACKET_ID:   cfg_q.packet_id_byte      <= cfg_data[7:0];
				CFG_CTRL_ONE:    cfg_q.control_word_one    <= cfg_data;
				CFG_CTRL_TWO:    cfg_q.control_word_two    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/aos_frame_builder_crc16.sv @@
// ----------------------------------------------------------------------------
// aos_frame_builder_crc16
// Byte-serial builder of an AOS-style transfer frame closed by a CRC-16-CCITT.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): cmd 0 loads data_byte into the payload
//   buffer, cmd 1 pulls the next frame byte. Loads past capacity, or while a
//   frame is partly sent, are dropped. Output channel (out_valid/out_ready)
//   carries one beat per pull: frame_byte, with frame_end high on the last
//   CRC byte. Frames are PAYLOAD_BYTES + 86 bytes long.
//   Throughput is one input beat per cycle unless the output stalls; a pull
//   reaches the output through the stage 1 register (payload buffer read
//   register), then the output register, where the CRC accumulator is updated.
//   When the receiver stalls, the output register holds its beat and the input
//   stage keeps taking one more beat; after that in_ready drops until the
//   output drains. A load held in the input stage never waits on the output.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
//   are meant for idle periods. Reset empties the buffer, rewinds the frame,
//   sets the frame counter to one, the CRC to all ones and the registers to
//   their defaults. The buffer contents need no clearing.
// ----------------------------------------------------------------------------
module aos_frame_builder_crc16 import aosfb_pkg::*; #(
	parameter int PAYLOAD_BYTES = 810
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [7:0]          data_byte,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          frame_byte,
	output logic                frame_end
);

	localparam int FrameBytes = PAYLOAD_BYTES + HeadBytes + TailBytes;
	localparam int PW         = $clog2(FrameBytes);
	localparam int CW         = $clog2(PAYLOAD_BYTES + 1);
	localparam int AW         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int TailPos    = HeadBytes + PAYLOAD_BYTES;
	localparam int CrcPos     = TailPos + TailBytes - 2;

	localparam logic [PW-1:0] LastPos     = PW'(FrameBytes - 1);
	localparam logic [PW-1:0] HeadPos     = PW'(HeadBytes);
	localparam logic [PW-1:0] TailPosC    = PW'(TailPos);
	localparam logic [PW-1:0] CrcFirstPos = PW'(CrcFirst);
	localparam logic [PW-1:0] CrcPosC     = PW'(CrcPos);
	localparam logic [CW-1:0] FullCount   = CW'(PAYLOAD_BYTES);

	cfg_t cfg;

	// frame state
	logic [CW-1:0] count_q;
	logic [PW-1:0] emit_q;
	logic [15:0]   fcnt_q;
	logic [15:0]   crc_q;

	// stage 1: accepted beat plus snapshots
	logic          valid_s1;
	logic          cmd_s1;
	logic [PW-1:0] pos_s1;
	logic [CW-1:0] cnt_s1;
	logic [15:0]   fcnt_s1;
	logic [7:0]    rd_s1;

	// output register
	logic          out_valid_q;
	logic [7:0]    frame_byte_q;
	logic          frame_end_q;

	logic          in_acc;
	logic          s1_go;
	logic          load_ok;
	logic          ram_re;
	logic [PW-1:0] rd_off;
	logic [PW-1:0] pay_off;
	logic [PW-1:0] tail_off;
	logic [15:0]   len_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	aosfb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake
	assign s1_go    = valid_s1 && (!cmd_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign in_acc   = in_valid && in_ready;

	// load gating and payload read address
	assign load_ok = in_acc && !cmd && (emit_q == '0) && (count_q < FullCount);
	assign rd_off  = emit_q - HeadPos;
	assign ram_re  = in_acc && cmd && (emit_q >= HeadPos) && (emit_q < TailPosC);

	aosfb_payload_ram #(
		.DEPTH (PAYLOAD_BYTES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (count_q[AW-1:0]),
		.wdata (data_byte),
		.re    (ram_re),
		.raddr (rd_off[AW-1:0]),
		.rdata (rd_s1)
	);

	// frame state update at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			emit_q  <= '0;
			fcnt_q  <= 16'd1;
		end else if (in_acc) begin
			if (cmd) begin
				if (emit_q == LastPos) begin
					emit_q  <= '0;
					count_q <= '0;
					fcnt_q  <= fcnt_q + 16'd1;
				end else begin
					emit_q <= emit_q + PW'(1);
				end
			end else if (load_ok) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1  <= cmd;
			pos_s1  <= emit_q;
			cnt_s1  <= count_q;
			fcnt_s1 <= fcnt_q;
		end
	end

	// frame byte select
	assign len_s1   = 16'(cnt_s1) + 16'(LenExtra);
	assign pay_off  = pos_s1 - HeadPos;
	assign tail_off = pos_s1 - TailPosC;
	assign last_s1  = (pos_s1 == LastPos);

	always_comb begin
		byte_s1 = 8'h00;
		if (pos_s1 >= TailPosC) begin
			case (tail_off[2:0])
				TailCw1Hi: byte_s1 = cfg.control_word_one[15:8];
				TailCw1Lo: byte_s1 = cfg.control_word_one[7:0];
				TailCw2Hi: byte_s1 = cfg.control_word_two[15:8];
				TailCw2Lo: byte_s1 = cfg.control_word_two[7:0];
				TailCrcHi: byte_s1 = crc_q[15:8];
				TailCrcLo: byte_s1 = crc_q[7:0];
				default:   byte_s1 = 8'h00;
			endcase
		end else if (pos_s1 >= HeadPos) begin
			byte_s1 = (pay_off < PW'(cnt_s1)) ? rd_s1 : 8'h00;
		end else begin
			case (pos_s1[6:0])
				PosSync0:  byte_s1 = Sync0;
				PosSync1:  byte_s1 = Sync1;
				PosSync2:  byte_s1 = Sync2;
				PosSync3:  byte_s1 = Sync3;
				PosChanHi: byte_s1 = cfg.channel_header_word[15:8];
				PosChanLo: byte_s1 = cfg.channel_header_word[7:0];
				PosFcHi:   byte_s1 = fcnt_s1[15:8];
				PosFcLo:   byte_s1 = fcnt_s1[7:0];
				PosDhdrHi: byte_s1 = cfg.data_header_word[15:8];
				PosDhdrLo: byte_s1 = cfg.data_header_word[7:0];
				PosLenHi:  byte_s1 = len_s1[15:8];
				PosLenLo:  byte_s1 = len_s1[7:0];
				PosPid:    byte_s1 = cfg.packet_id_byte;
				default:   byte_s1 = 8'h00;
			endcase
		end
	end

	// crc accumulator, advanced as each pull reaches the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CrcInit;
		end else if (s1_go && cmd_s1) begin
			if (last_s1) begin
				crc_q <= CrcInit;
			end else if (pos_s1 >= CrcFirstPos && pos_s1 < CrcPosC) begin
				crc_q <= crc16_byte(crc_q, byte_s1);
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && cmd_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat
	always_ff @(posedge clk) begin
		if (s1_go && cmd_s1) begin
			frame_byte_q <= byte_s1;
			frame_end_q  <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign frame_end  = frame_end_q;

endmodule

@@ bench/tb_aos_frame_builder_crc16.sv @@
// ----------------------------------------------------------------------------
// tb_aos_frame_builder_crc16
// Self-checking bench for the AOS transfer frame builder. Loads and pulls are
// driven over the input handshake, every frame byte is predicted by a local
// model of the frame layout and running CRC-16-CCITT, and each output beat is
// compared in order. One full frame covers reset values, a buffer filled past
// capacity and loads dropped mid-frame, with random control words in its tail;
// the head of the next frame checks all-ones registers. Three sender/receiver
// idle mixes run in turn.
// ----------------------------------------------------------------------------
module tb_aos_frame_builder_crc16;
	timeunit 1ns;
	timeprecision 1ps;
	import aosfb_pkg::*;

	localparam int PayloadBytes = 810;
	localparam int FrameBytes   = HeadBytes + PayloadBytes + TailBytes;
	localparam int CrcStop      = HeadBytes + PayloadBytes + TailCrcHi;
	localparam int HeadPull     = HeadBytes + PayloadBytes / 2;
	localparam int DrainCycles  = 6;
	localparam int CycleLimit   = 300000;

	// command codes of the input beat
	localparam logic CmdLoad = 1'b0;
	localparam logic CmdPull = 1'b1;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} frame_beat_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic                cmd       = CmdLoad;
	logic [7:0]          data_byte = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          frame_byte;
	logic                frame_end;

	// frame model state
	logic [7:0]  pay_buf [PayloadBytes];
	int unsigned pay_len;
	int unsigned emit_pos;
	logic [15:0] frame_cnt;
	logic [15:0] crc_run;
	cfg_t        regs;

	frame_beat_t expected_beats[$];
	int          err_count   = 0;
	int          send_pct    = 21;
	int          recv_pct    = 62;
	longint      cycle_count = 0;

	aos_frame_builder_crc16 #(
		.PAYLOAD_BYTES(PayloadBytes)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.frame_byte(frame_byte),
		.frame_end (frame_end)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// crc-16-ccitt, one message bit at a time, msb first
	function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
			input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
		end
		return c;
	endfunction

	// byte of the frame under construction at position p
	function automatic logic [7:0] frame_byte_at(input int unsigned p);
		logic [15:0] len_field;
		logic [2:0]  toff;
		logic [6:0]  hp;
		len_field = 16'(pay_len + LenExtra);
		if (p >= HeadBytes + PayloadBytes) begin
			toff = 3'(p - HeadBytes - PayloadBytes);
			case (toff)
				TailCw1Hi: return regs.control_word_one[15:8];
				TailCw1Lo: return regs.control_word_one[7:0];
				TailCw2Hi: return regs.control_word_two[15:8];
				TailCw2Lo: return regs.control_word_two[7:0];
				TailCrcHi: return crc_run[15:8];
				TailCrcLo: return crc_run[7:0];
				default:   return 8'h00;
			endcase
		end
		// payload, zero padded past the loaded length
		if (p >= HeadBytes)
			return (p - HeadBytes < pay_len) ? pay_buf[p - HeadBytes] : 8'h00;
		hp = 7'(p);
		case (hp)
			PosSync0:  return Sync0;
			PosSync1:  return Sync1;
			PosSync2:  return Sync2;
			PosSync3:  return Sync3;
			PosChanHi: return regs.channel_header_word[15:8];
			PosChanLo: return regs.channel_header_word[7:0];
			PosFcHi:   return frame_cnt[15:8];
			PosFcLo:   return frame_cnt[7:0];
			PosDhdrHi: return regs.data_header_word[15:8];
			PosDhdrLo: return regs.data_header_word[7:0];
			PosLenHi:  return len_field[15:8];
			PosLenLo:  return len_field[7:0];
			PosPid:    return regs.packet_id_byte;
			default:   return 8'h00;
		endcase
	endfunction

	function automatic cfg_t random_regs();
		cfg_t r;
		r.channel_header_word = 16'($urandom);
		r.data_header_word    = 16'($urandom);
		r.packet_id_byte      = 8'($urandom);
		r.control_word_one    = 16'($urandom);
		r.control_word_two    = 16'($urandom);
		return r;
	endfunction

	task automatic frame_model_reset();
		pay_len   = 0;
		emit_pos  = 0;
		frame_cnt = 16'd1;
		crc_run   = CrcInit;
		regs.channel_header_word = ChannelHdrRst;
		regs.data_header_word    = DataHdrRst;
		regs.packet_id_byte      = PacketIdRst;
		regs.control_word_one    = CtrlOneRst;
		regs.control_word_two    = CtrlTwoRst;
	endtask

	// advance the frame model by one accepted beat
	task automatic frame_model_step(input logic c, input logic [7:0] d);
		frame_beat_t beat;
		if (c == CmdLoad) begin
			// loads only land between frames and while there is room
			if (emit_pos == 0 && pay_len < PayloadBytes) begin
				pay_buf[pay_len] = d;
				pay_len++;
			end
		end else begin
			beat.value = frame_byte_at(emit_pos);
			if (emit_pos >= CrcFirst && emit_pos < CrcStop)
				crc_run = crc_ccitt_step(crc_run, beat.value);
			beat.last = (emit_pos + 1 >= FrameBytes);
			expected_beats.push_back(beat);
			if (beat.last) begin
				emit_pos  = 0;
				pay_len   = 0;
				crc_run   = CrcInit;
				frame_cnt = frame_cnt + 16'd1;
			end else begin
				emit_pos++;
			end
		end
	endtask

	// send one input beat, with random idle cycles ahead of it
	task automatic send_cmd_beat(input logic c, input logic [7:0] d);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		data_byte <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		frame_model_step(c, d);
	endtask

	task automatic load_bytes(input int n);
		repeat (n) send_cmd_beat(CmdLoad, 8'($urandom));
	endtask

	// pull n frame bytes, with some loads mixed in
	task automatic pull_bytes(input int n, input int noise_pct);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < noise_pct)
				send_cmd_beat(CmdLoad, 8'($urandom));
			send_cmd_beat(CmdPull, 8'($urandom));
		end
	endtask

	// wait until every expected beat is out and the pipeline is quiet
	task automatic wait_frame_drain();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_CHANNEL_HDR: regs.channel_header_word = val;
			CFG_DATA_HDR:    regs.data_header_word    = val;
			CFG_PACKET_ID:   regs.packet_id_byte      = val[7:0];
			CFG_CTRL_ONE:    regs.control_word_one    = val;
			CFG_CTRL_TWO:    regs.control_word_two    = val;
			default:         ;
		endcase
	endtask

	// write the whole register set, then junk to the unused indexes
	task automatic load_regs(input cfg_t r);
		write_reg(CFG_CHANNEL_HDR, r.channel_header_word);
		write_reg(CFG_DATA_HDR, r.data_header_word);
		write_reg(CFG_PACKET_ID, {8'($urandom), r.packet_id_byte});
		write_reg(CFG_CTRL_ONE, r.control_word_one);
		write_reg(CFG_CTRL_TWO, r.control_word_two);
		for (int i = int'(CFG_CTRL_TWO) + 1; i < (1 << CfgIdxW); i++)
			write_reg(CfgIdxW'(i), 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// buffer filled past capacity under reset registers
	task automatic test_fill_past_capacity();
		send_cmd_beat(CmdLoad, 8'h00);
		send_cmd_beat(CmdLoad, 8'hFF);
		send_cmd_beat(CmdLoad, 8'h55);
		send_cmd_beat(CmdLoad, 8'hAA);
		load_bytes(PayloadBytes - 4 + 6);
	endtask

	// frame head and first half of the payload; loads after the first pull are dropped
	task automatic test_frame_head_and_payload();
		pull_bytes(HeadPull, 3);
		wait_frame_drain();
	endtask

	// random control words, rest of the frame with crc, loads right after the end
	task automatic test_frame_tail_and_crc();
		load_regs(random_regs());
		pull_bytes(FrameBytes - HeadPull, 3);
		load_bytes(3);
		wait_frame_drain();
	endtask

	// all-ones registers in the head of the next frame
	task automatic test_extreme_header();
		load_regs('1);
		pull_bytes(HeadBytes + 160, 5);
		wait_frame_drain();
	endtask

	// output side: check each accepted beat, then pick the next ready
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				err_count++;
				$display("%0t unexpected beat: expected none, actual byte %h end %b",
					$time, frame_byte, frame_end);
			end else begin
				want = expected_beats.pop_front();
				if (frame_byte !== want.value) begin
					err_count++;
					$display("%0t frame_byte mismatch: expected %h actual %h",
						$time, want.value, frame_byte);
				end
				if (frame_end !== want.last) begin
					err_count++;
					$display("%0t frame_end mismatch: expected %b actual %b",
						$time, want.last, frame_end);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_pct);
	end

	// test sequence
	initial begin
		frame_model_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_pct = 21;
		recv_pct = 62;
		test_fill_past_capacity();
		test_frame_head_and_payload();
		send_pct = 62;
		recv_pct = 21;
		test_frame_tail_and_crc();
		send_pct = 0;
		recv_pct = 0;
		test_extreme_header();
		if (err_count == 0 && expected_beats.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/aosfb_pkg.sv
hdl/aosfb_payload_ram.sv
hdl/aosfb_cfg_regs.sv
hdl/aos_frame_builder_crc16.sv
bench/tb_aos_frame_builder_crc16.sv
